[src/dcas_pkg.sv]
// Shared types and constants for the DMA channel address sequencer.
// No dependencies; every other file imports this package.
package dcas_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CTRL_W = 32;
  localparam int unsigned COUNT_W = 21;
  localparam int unsigned RUN_EN_BIT = 31;
  localparam int unsigned WIDE_BIT = 26;
  localparam int unsigned DEST_MODE_LSB = 21;
  localparam int unsigned SRC_MODE_LSB = 23;

  // Address step modes (control bits 22..21 and 24..23)
  localparam logic [1:0] MODE_INC = 2'd0;
  localparam logic [1:0] MODE_DEC = 2'd1;
  localparam logic [1:0] MODE_FIX = 2'd2;
  localparam logic [1:0] MODE_ALT = 2'd3;

  typedef enum logic [1:0] {
    CMD_WR_SRC  = 2'd0,
    CMD_WR_DEST = 2'd1,
    CMD_WR_CTRL = 2'd2,
    CMD_STEP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_SRC_BLK  = 2'd1,
    FAULT_DEST_BLK = 2'd2,
    FAULT_ALIGN    = 2'd3
  } fault_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] write_data;
    logic              source_blocked;
    logic              dest_blocked;
  } req_t;

  typedef struct packed {
    logic              issue_transfer;
    logic [ADDR_W-1:0] read_address;
    logic [ADDR_W-1:0] write_address;
    logic              word_wide;
    fault_t            fault_code;
    logic              finished;
    logic              busy_res;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [CTRL_W-1:0] ctrl;
  } chan_state_t;

endpackage

[src/dcas_if.sv]
// Valid/ready channel interfaces for command beats and result beats.
// Depends on dcas_pkg.
interface dcas_req_if;
  import dcas_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dcas_rsp_if;
  import dcas_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/dcas_step.sv]
// Per-beat channel logic: register writes, fault check, address step, count.
// Depends on dcas_pkg.
module dcas_step (
  input  dcas_pkg::chan_state_t cur,
  input  dcas_pkg::req_t        req,
  output dcas_pkg::chan_state_t nxt,
  output dcas_pkg::rsp_t        res
);
  import dcas_pkg::*;

  function automatic logic [ADDR_W-1:0] move_addr(
    input logic [ADDR_W-1:0] a,
    input logic [1:0]        mode,
    input logic              is_dest,
    input logic [ADDR_W-1:0] sz
  );
    logic [ADDR_W-1:0] r;
    begin
      r = a;
      if (mode == MODE_DEC) begin
        r = a - sz;
      end else if (mode == MODE_INC || (is_dest && mode == MODE_ALT)) begin
        r = a + sz;
      end
      return r;
    end
  endfunction

  logic               run;
  logic               wide;
  logic [ADDR_W-1:0]  sz;
  logic [1:0]         amask;
  logic [COUNT_W-1:0] count;
  logic               last;

  assign wide  = cur.ctrl[WIDE_BIT];
  assign sz    = wide ? ADDR_W'(4) : ADDR_W'(2);
  assign amask = wide ? 2'b11 : 2'b01;
  assign count = cur.ctrl[COUNT_W-1:0];
  assign run   = (req.cmd == CMD_STEP) && cur.ctrl[RUN_EN_BIT] && (|count);
  assign last  = (count == COUNT_W'(1));

  always_comb begin
    nxt = cur;
    unique case (req.cmd)
      CMD_WR_SRC:  nxt.src  = req.write_data;
      CMD_WR_DEST: nxt.dst  = req.write_data;
      CMD_WR_CTRL: nxt.ctrl = req.write_data;
      CMD_STEP:    ;
    endcase

    // Addresses and width are shown as they stand before the step moves them
    res.read_address   = nxt.src;
    res.write_address  = nxt.dst;
    res.word_wide      = nxt.ctrl[WIDE_BIT];
    res.issue_transfer = 1'b0;
    res.fault_code     = FAULT_NONE;
    res.finished       = 1'b0;

    if (run) begin
      priority if (req.source_blocked) begin
        res.fault_code = FAULT_SRC_BLK;
      end else if (req.dest_blocked) begin
        res.fault_code = FAULT_DEST_BLK;
      end else if (|((cur.src[1:0] | cur.dst[1:0]) & amask)) begin
        res.fault_code = FAULT_ALIGN;
      end else begin
        res.fault_code = FAULT_NONE;
      end
      res.issue_transfer = (res.fault_code == FAULT_NONE);
      nxt.dst = move_addr(cur.dst, cur.ctrl[DEST_MODE_LSB +: 2], 1'b1, sz);
      nxt.src = move_addr(cur.src, cur.ctrl[SRC_MODE_LSB +: 2], 1'b0, sz);
      // count is nonzero, so the decrement never borrows past the count field
      if (last) begin
        nxt.ctrl     = '0;
        res.finished = 1'b1;
      end else begin
        nxt.ctrl[COUNT_W-1:0] = count - COUNT_W'(1);
      end
    end

    res.busy_res = nxt.ctrl[RUN_EN_BIT] && (|nxt.ctrl[COUNT_W-1:0]);
  end

endmodule

[src/dma_channel_address_sequencer.sv]
// Top level: command input register, channel state, step logic, result register.
// Depends on dcas_pkg, dcas_if and dcas_step.
//
//  channel | dir | beat carries
//  --------+-----+-------------------------------------------------------------
//  req     | in  | cmd, write_data, source_blocked, dest_blocked
//  rsp     | out | issue_transfer, read/write_address, word_wide, fault, status
//
// One result beat per command beat; a new command is taken every cycle unless a stalled result fills both stages.
// A command passes through the input register, then the step logic into the result register.
// The channel registers update as a command moves into the result register.
// A stalled result holds both stages; req.ready drops only when both are full.
// rst (synchronous) clears the stage valids and the channel registers to zero.
module dma_channel_address_sequencer (
  input logic       clk,
  input logic       rst,
  dcas_req_if.sink   req,
  dcas_rsp_if.source rsp
);
  import dcas_pkg::*;

  logic        s1_valid;
  req_t        s1_req;
  logic        out_valid;
  rsp_t        out_res;
  chan_state_t state;
  chan_state_t state_next;
  rsp_t        res_next;
  logic        advance;

  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || advance;

  dcas_step u_step (
    .cur (state),
    .req (s1_req),
    .nxt (state_next),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          state <= state_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_req <= req.payload;
    end
    if (advance && s1_valid) begin
      out_res <= res_next;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_res;

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && res_next.finished) |=> (state.ctrl == '0))
    else $error("control not cleared after final unit");

  a_issue_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.issue_transfer) |-> (out_res.fault_code == FAULT_NONE))
    else $error("transfer issued with a fault");

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.finished) |-> !out_res.busy_res)
    else $error("busy after final unit");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> $stable(state))
    else $error("channel state moved during a stall");

  a_fault_step: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && s1_req.cmd != CMD_STEP)
      |-> (!res_next.issue_transfer && res_next.fault_code == FAULT_NONE))
    else $error("register write produced a transfer or fault");

endmodule
